// File: hdl/dtsd_pkg.sv
// ----------------------------------------------------------------------------
// dtsd_pkg: shared types and constants of the step detector
// widths of the scaled samples and window values, the item carried
// between front and back, the configuration bundle and its indexes
// ----------------------------------------------------------------------------
package dtsd_pkg;

  // three accelerometer axes
  localparam int AXES = 3;

  // field widths
  localparam int RAW_W = 16;
  localparam int QUO_W = 9;
  localparam int MM_W = 12;
  localparam int WIN_W = 8;
  localparam int CNT_W = 16;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_PRECISION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd2;

  // reset values of the configuration registers
  localparam logic [QUO_W-1:0] CHANGE_PRECISION_RST = 9'd30;
  localparam logic [QUO_W-1:0] SWING_THRESHOLD_RST = 9'd60;
  localparam logic [WIN_W-1:0] WINDOW_LENGTH_RST = 8'd50;

  // restart value of the window minimum
  localparam logic [MM_W-1:0] MIN_RESTART = 12'd2048;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  // scaled item as handed from front to back
  typedef struct packed {
    logic                        action;
    logic [AXES-1:0][QUO_W-1:0] quo;
    logic [CNT_W-1:0]            load_value;
  } dtsd_item_t;

  // configuration register bundle
  typedef struct packed {
    logic [QUO_W-1:0] change_precision;
    logic [QUO_W-1:0] swing_threshold;
    logic [WIN_W-1:0] window_length;
  } dtsd_cfg_t;

endpackage

// File: hdl/dtsd_front.sv
// ----------------------------------------------------------------------------
// dtsd_front: input stage of the step detector
// registers each incoming item, splits sample from load, and scales
// the raw axis words by 1/164 with a reciprocal multiply
// ----------------------------------------------------------------------------
module dtsd_front import dtsd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [4*RAW_W-1:0]     s_tdata,
  input  logic                   s_tuser,
  output logic                   push,
  output dtsd_item_t             push_item,
  input  logic                   q_full
);

  // 164 = 4 * 41: drop two bits, then multiply by ceil(2^20 / 41)
  localparam int RAW_DIVISOR = 164;
  localparam int RAW_PRE_SHIFT = 2;
  localparam int RAW_ODD = RAW_DIVISOR >> RAW_PRE_SHIFT;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W = 15;
  localparam int RECIP_PROD_W = RAW_W - RAW_PRE_SHIFT + RECIP_W;
  localparam logic [RECIP_W-1:0] RAW_RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + RAW_ODD - 1) / RAW_ODD);

  logic                         f_valid;
  logic                         f_action;
  logic [AXES-1:0][RAW_W-1:0]   f_raw;
  logic [CNT_W-1:0]             f_load;
  logic                         accept;
  logic [RECIP_PROD_W-1:0]      prod [AXES];

  // handshake: hold stage frees when its item goes to the queue
  assign s_tready = !f_valid || !q_full;
  assign accept = s_tvalid && s_tready;
  assign push = f_valid && !q_full;

  // input hold stage
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_action <= s_tuser;
      f_raw <= s_tdata[AXES*RAW_W-1:0];
      f_load <= s_tdata[AXES*RAW_W +: CNT_W];
    end
  end

  // scale each axis by 1/164
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      prod[a] = RECIP_PROD_W'(f_raw[a][RAW_W-1:RAW_PRE_SHIFT]) *
                RECIP_PROD_W'(RAW_RECIP);
    end
  end

  always_comb begin
    push_item.action = f_action;
    push_item.load_value = f_load;
    for (int a = 0; a < AXES; a++) begin
      push_item.quo[a] = prod[a][RECIP_SHIFT +: QUO_W];
    end
  end

endmodule

// File: hdl/dtsd_queue.sv
// ----------------------------------------------------------------------------
// dtsd_queue: short item queue between front and back
// four entries in registers, one write and one read a cycle
// ----------------------------------------------------------------------------
module dtsd_queue import dtsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  dtsd_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output dtsd_item_t head
);

  dtsd_item_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign head = slots[rd_ptr];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// File: hdl/dtsd_back.sv
// ----------------------------------------------------------------------------
// dtsd_back: averaging, window tracking and step decision
// five stages moving together: accumulate, average, window update,
// swing and midpoint, step decision into the output register
// ----------------------------------------------------------------------------
module dtsd_back import dtsd_pkg::*; #(
  parameter int AVERAGE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  dtsd_cfg_t        cfg,
  input  logic             q_valid,
  input  dtsd_item_t       q_item,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [CNT_W-1:0] m_tdata,
  output logic [1:0]       m_tuser
);

  localparam int FILL_W = $clog2(AVERAGE_DEPTH);
  localparam int SUM_W = QUO_W + FILL_W;
  localparam logic [FILL_W-1:0] LAST_FILL = FILL_W'(AVERAGE_DEPTH - 1);
  // sum / depth as multiply by ceil(2^k / depth), exact for SUM_W-bit sums
  localparam int AVG_SHIFT = SUM_W + FILL_W;
  localparam int AVG_MULT_W = SUM_W + 2;
  localparam int PROD_W = 2 * SUM_W + 2;
  localparam logic [AVG_MULT_W-1:0] AVG_MULT =
    AVG_MULT_W'(((1 << AVG_SHIFT) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH);

  logic adv;

  // accumulate state
  logic [SUM_W-1:0]        sums [AXES];
  logic [SUM_W-1:0]        sum_add [AXES];
  logic [FILL_W-1:0]       fill_index;
  logic                    fill_last;

  // stage 1
  logic                    s1_valid;
  logic                    s1_load;
  logic                    s1_avg;
  logic [CNT_W-1:0]        s1_load_value;
  logic [SUM_W-1:0]        s1_sum [AXES];

  // stage 2
  logic [PROD_W-1:0]       avg_prod [AXES];
  logic                    s2_valid;
  logic                    s2_load;
  logic                    s2_avg;
  logic [CNT_W-1:0]        s2_load_value;
  logic [QUO_W-1:0]        s2_avg_val [AXES];

  // window state
  logic [WIN_W-1:0]        window_index;
  logic [WIN_W:0]          win_inc;
  logic                    roll;
  logic [MM_W-1:0]         current_max [AXES];
  logic [MM_W-1:0]         current_min [AXES];
  logic [MM_W-1:0]         previous_max [AXES];
  logic [MM_W-1:0]         previous_min [AXES];
  logic [QUO_W-1:0]        tracked_new [AXES];
  logic [QUO_W-1:0]        tracked_old [AXES];
  logic                    win_update;

  // stage 3
  logic                    s3_valid;
  logic                    s3_load;
  logic                    s3_avg;
  logic [CNT_W-1:0]        s3_load_value;

  // stage 4
  logic [MM_W-1:0]         swing [AXES];
  logic [MM_W:0]           mid_sum [AXES];
  logic                    s4_valid;
  logic                    s4_load;
  logic                    s4_avg;
  logic [CNT_W-1:0]        s4_load_value;
  logic [MM_W-1:0]         s4_swing [AXES];
  logic [MM_W-1:0]         s4_mid [AXES];
  logic [QUO_W-1:0]        s4_trk_old [AXES];
  logic [QUO_W-1:0]        s4_trk_new [AXES];

  // decision
  logic [AXES-1:0]         lead;
  logic [AXES-1:0]         crossing;
  logic                    step_hit;
  logic [CNT_W-1:0]        step_total;
  logic [CNT_W-1:0]        step_total_next;

  // whole pipeline moves when the output register is free
  assign adv = !m_tvalid || m_tready;
  assign pop = adv && q_valid;

  // stage 1: per-axis sums over AVERAGE_DEPTH samples
  assign fill_last = fill_index == LAST_FILL;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sum_add[a] = sums[a] + SUM_W'(q_item.quo[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_avg <= 1'b0;
      fill_index <= '0;
      for (int a = 0; a < AXES; a++) begin
        sums[a] <= '0;
      end
    end else if (adv) begin
      s1_valid <= q_valid;
      s1_avg <= q_valid && !q_item.action && fill_last;
      if (q_valid && !q_item.action) begin
        if (fill_last) begin
          fill_index <= '0;
          for (int a = 0; a < AXES; a++) begin
            sums[a] <= '0;
          end
        end else begin
          fill_index <= fill_index + 1'b1;
          for (int a = 0; a < AXES; a++) begin
            sums[a] <= sum_add[a];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_load <= q_item.action;
      s1_load_value <= q_item.load_value;
      for (int a = 0; a < AXES; a++) begin
        s1_sum[a] <= sum_add[a];
      end
    end
  end

  // stage 2: average by reciprocal multiply
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      avg_prod[a] = PROD_W'(s1_sum[a]) * PROD_W'(AVG_MULT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_avg <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      s2_avg <= s1_valid && s1_avg;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_load <= s1_load;
      s2_load_value <= s1_load_value;
      for (int a = 0; a < AXES; a++) begin
        s2_avg_val[a] <= avg_prod[a][AVG_SHIFT +: QUO_W];
      end
    end
  end

  // stage 3: window roll, max/min and tracked sample update
  assign win_update = adv && s2_valid && s2_avg;
  assign win_inc = {1'b0, window_index} + 1'b1;
  assign roll = win_inc > {1'b0, cfg.window_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_index <= '0;
      for (int a = 0; a < AXES; a++) begin
        current_max[a] <= '0;
        current_min[a] <= MIN_RESTART;
        previous_max[a] <= '0;
        previous_min[a] <= '0;
        tracked_new[a] <= '0;
        tracked_old[a] <= '0;
      end
    end else if (win_update) begin
      window_index <= roll ? WIN_W'(1) : win_inc[WIN_W-1:0];
      for (int a = 0; a < AXES; a++) begin
        logic [MM_W-1:0]  base_max;
        logic [MM_W-1:0]  base_min;
        logic [MM_W-1:0]  avg_w;
        logic [QUO_W-1:0] diff;
        base_max = roll ? '0 : current_max[a];
        base_min = roll ? MIN_RESTART : current_min[a];
        avg_w = MM_W'(s2_avg_val[a]);
        diff = (s2_avg_val[a] >= tracked_new[a]) ? s2_avg_val[a] - tracked_new[a]
                                                 : tracked_new[a] - s2_avg_val[a];
        if (roll) begin
          previous_max[a] <= current_max[a];
          previous_min[a] <= current_min[a];
        end
        current_max[a] <= (avg_w > base_max) ? avg_w : base_max;
        current_min[a] <= (avg_w < base_min) ? avg_w : base_min;
        tracked_old[a] <= tracked_new[a];
        if (diff > cfg.change_precision) begin
          tracked_new[a] <= s2_avg_val[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s3_avg <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
      s3_avg <= s2_valid && s2_avg;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_load <= s2_load;
      s3_load_value <= s2_load_value;
    end
  end

  // stage 4: swings and previous-window midpoints, snapshot of tracking
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      swing[a] = (current_max[a] >= current_min[a]) ? current_max[a] - current_min[a]
                                                   : current_min[a] - current_max[a];
      mid_sum[a] = {1'b0, previous_max[a]} + {1'b0, previous_min[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s4_avg <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
      s4_avg <= s3_valid && s3_avg;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_load <= s3_load;
      s4_load_value <= s3_load_value;
      for (int a = 0; a < AXES; a++) begin
        s4_swing[a] <= swing[a];
        s4_mid[a] <= mid_sum[a][MM_W:1];
        s4_trk_old[a] <= tracked_old[a];
        s4_trk_new[a] <= tracked_new[a];
      end
    end
  end

  // stage 5: pick the clearly leading active axis and look for a fall
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      lead[a] = s4_swing[a] >= MM_W'(cfg.swing_threshold);
      for (int b = 0; b < AXES; b++) begin
        if (b != a && !(s4_swing[a] > s4_swing[b])) begin
          lead[a] = 1'b0;
        end
      end
      crossing[a] = (MM_W'(s4_trk_old[a]) > s4_mid[a]) &&
                    (MM_W'(s4_trk_new[a]) < s4_mid[a]);
    end
  end

  assign step_hit = s4_valid && s4_avg && ((lead & crossing) != '0);

  // step total: load wins, otherwise count the step
  always_comb begin
    step_total_next = step_total;
    priority if (s4_valid && s4_load) begin
      step_total_next = s4_load_value;
    end else if (step_hit) begin
      step_total_next = step_total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_total <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      step_total <= step_total_next;
      m_tvalid <= s4_valid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= step_total_next;
      m_tuser <= {step_hit, s4_avg && !s4_load};
    end
  end

endmodule

// File: hdl/dynamic_threshold_step_detector.sv
// ----------------------------------------------------------------------------
// dynamic_threshold_step_detector: pedometer with dynamic threshold
// scales raw three-axis samples, averages them, tracks max/min per
// window and counts a step when the leading axis falls through the
// previous window's midpoint
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------
//   s_       | in  | s_tvalid/s_tready  | tdata: accel_x, accel_y, accel_z,
//            |     |                    |   load_value; tuser: action
//   m_       | out | m_tvalid/m_tready  | tdata: step_count;
//            |     |                    |   tuser: average_done, step_seen
//   cfg_     | in  | cfg_we             | cfg_index, cfg_data
//
// one item per cycle sustained when nothing stalls; a result passes the
// hold stage, the queue and the five back stages before it leaves
// the window and max/min update of one average is registered in back stage 3
// reset is synchronous; no clearing pass
// an output stall fills the four-entry queue, then s_tready drops
// ----------------------------------------------------------------------------
module dynamic_threshold_step_detector import dtsd_pkg::*; #(
  parameter int AVERAGE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32], load_value [63:48]
  input  logic [4*RAW_W-1:0]    s_tdata,
  // action
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // step_count [15:0]
  output logic [CNT_W-1:0]      m_tdata,
  // average_done [0], step_seen [1]
  output logic [1:0]            m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dtsd_cfg_t   cfg;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  dtsd_item_t  push_item;
  dtsd_item_t  q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.change_precision <= CHANGE_PRECISION_RST;
      cfg.swing_threshold <= SWING_THRESHOLD_RST;
      cfg.window_length <= WINDOW_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANGE_PRECISION: cfg.change_precision <= cfg_data;
        CFG_SWING_THRESHOLD:  cfg.swing_threshold <= cfg_data;
        CFG_WINDOW_LENGTH:    cfg.window_length <= cfg_data[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: hold stage and scaling
  dtsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (q_push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  // queue between front and back
  dtsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // back: averaging, window and step decision
  dtsd_back #(
    .AVERAGE_DEPTH (AVERAGE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_head),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // last delivered count, for the step check
  logic [CNT_W-1:0] seen_count;
  logic             seen_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any <= 1'b0;
      seen_count <= '0;
    end else if (m_tvalid && m_tready) begin
      seen_any <= 1'b1;
      seen_count <= m_tdata;
    end
  end

  // a step only comes with a finished average
  a_step_needs_average: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] || !m_tuser[1]))
    else $error("step flagged without a finished average");

  // a stalled output freezes the back end, so the queue is not drained
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !q_pop)
    else $error("queue popped while output stalled");

  // a step adds exactly one to the count delivered before it
  a_step_increments: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser[1] && seen_any) |->
      (m_tdata == CNT_W'(seen_count + 1'b1)))
    else $error("step count did not advance by one");

  // the back end never pops an empty queue
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_valid && !(q_push && q_full)))
    else $error("queue pop without an item");

endmodule
